### rtl/mesh_vertex_morph_lerp_core_defines.svh
// Assertion macros shared by the vertex morph RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef MESH_VERTEX_MORPH_LERP_CORE_DEFINES_SVH
`define MESH_VERTEX_MORPH_LERP_CORE_DEFINES_SVH

// Check that a signed value sits within [lo, hi] whenever en is high
`define MVML_ASSERT_RANGE(lbl, en, val, lo, hi) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (en) |-> (((val) >= (lo)) && ((val) <= (hi)))) \
        else $error("value out of range");

// Check a same-cycle implication
`define MVML_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) \
        else $error("implication failed");

`endif

### rtl/mvml_pkg.sv
// Package for the vertex morph core: payload and sideband types,
// widths and the constant sine table. Depends on nothing.
`default_nettype none

package mvml_pkg;

    localparam int LANES    = 3;
    localparam int POS_W    = 20;
    localparam int NORM_W   = 16;
    localparam int WGT_W    = 17;
    localparam int SQ_W     = 62;
    localparam int SQ_STEPS = 31;
    localparam int ROOT_W   = 31;
    localparam int CABS_W   = 31;
    localparam int DIVD_W   = 45;
    localparam int DV_STEPS = 15;
    localparam int Q_W      = 15;

    localparam int LUT_SIZE = 256;
    localparam int LUT_BITS = 8;

    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [15:0] new_pos_x;
        logic signed [15:0] new_pos_y;
        logic signed [15:0] new_pos_z;
        logic [15:0]        new_normal_code;
        logic signed [15:0] old_pos_x;
        logic signed [15:0] old_pos_y;
        logic signed [15:0] old_pos_z;
        logic [15:0]        old_normal_code;
    } vin_t;

    typedef struct packed {
        logic signed [19:0] out_pos_x;
        logic signed [19:0] out_pos_y;
        logic signed [19:0] out_pos_z;
        logic signed [15:0] out_norm_x;
        logic signed [15:0] out_norm_y;
        logic signed [15:0] out_norm_z;
    } vout_t;

    // Sideband riding along the square-root pipeline
    typedef struct packed {
        logic [LANES-1:0][POS_W-1:0]  pos;
        logic [LANES-1:0][NORM_W-1:0] unb;
        logic                         wz;
        logic [LANES-1:0][CABS_W-1:0] c_abs;
        logic [LANES-1:0]             c_neg;
    } sq_side_t;

    // Sideband riding along the divider pipeline
    typedef struct packed {
        logic [LANES-1:0][POS_W-1:0]  pos;
        logic [LANES-1:0][NORM_W-1:0] unb;
        logic                         wz;
        logic [LANES-1:0]             c_neg;
        logic                         m_zero;
    } div_side_t;

    typedef logic signed [15:0] sine_lut_t [LUT_SIZE];

    // Eight-term Taylor sine of a Q30 angle in [0, pi/2], Q14 result
    function automatic logic [15:0] quarter_sine(input logic [63:0] xin);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x = (xin > HALF_PI_Q30) ? HALF_PI_Q30 : xin;
        x2 = (x * x) >> 30;
        term = x;
        sum = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        if (sum < 0)
            sum = 0;
        sum = (sum + 64'sd32768) >>> 16;
        if (sum > 64'sd16384)
            sum = 64'sd16384;
        return sum[15:0];
    endfunction

    // Full-wave table folded from the quarter wave; one entry per code step
    function automatic sine_lut_t build_lut();
        sine_lut_t   lut;
        logic [63:0] j;
        logic        neg;
        logic [15:0] s;
        for (int i = 0; i < LUT_SIZE; i++) begin
            neg = 1'b0;
            if (i <= LUT_SIZE / 4)
                j = 64'(i);
            else if (i <= LUT_SIZE / 2)
                j = 64'(LUT_SIZE / 2 - i);
            else if (i <= 3 * LUT_SIZE / 4)
            begin
                j = 64'(i - LUT_SIZE / 2);
                neg = 1'b1;
            end
            else
            begin
                j = 64'(LUT_SIZE - i);
                neg = 1'b1;
            end
            s = quarter_sine((j * TWO_PI_Q30) >> LUT_BITS);
            lut[i] = neg ? -$signed(s) : $signed(s);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_lut();

endpackage

`default_nettype wire

### rtl/mvml_isqrt_pipe.sv
// Fully pipelined integer square root, one result bit per stage.
// Depends on mvml_pkg for widths and the sideband type.
`default_nettype none

module mvml_isqrt_pipe (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [mvml_pkg::SQ_W-1:0]     radicand,
    input  wire mvml_pkg::sq_side_t            in_side,
    output logic                               out_valid,
    output logic [mvml_pkg::ROOT_W-1:0]        root,
    output mvml_pkg::sq_side_t                 out_side
);

    localparam int N = mvml_pkg::SQ_STEPS;
    localparam int W = mvml_pkg::SQ_W;

    logic [W-1:0]         v_src [N];
    logic [W-1:0]         r_src [N];
    logic [W-1:0]         v_next [N];
    logic [W-1:0]         r_next [N];
    logic [W-1:0]         v_reg [N];
    logic [W-1:0]         r_reg [N];
    logic [N-1:0]         vld_reg;
    mvml_pkg::sq_side_t   side_reg [N];

    // Compute one remainder/root step per stage
    always_comb
    begin
        logic [W-1:0] bitv;
        logic [W-1:0] t;
        v_src[0] = radicand;
        r_src[0] = '0;
        for (int s = 1; s < N; s++)
        begin
            v_src[s] = v_reg[s-1];
            r_src[s] = r_reg[s-1];
        end
        for (int s = 0; s < N; s++)
        begin
            bitv = {{(W-1){1'b0}}, 1'b1} << (2 * (N - 1 - s));
            t = r_src[s] + bitv;
            if (v_src[s] >= t)
            begin
                v_next[s] = v_src[s] - t;
                r_next[s] = (r_src[s] >> 1) + bitv;
            end
            else
            begin
                v_next[s] = v_src[s];
                r_next[s] = r_src[s] >> 1;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    // Advance data and sideband
    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int s = 0; s < N; s++)
        begin
            v_reg[s] <= v_next[s];
            r_reg[s] <= r_next[s];
        end
        for (int s = 1; s < N; s++)
            side_reg[s] <= side_reg[s-1];
    end

    assign out_valid = vld_reg[N-1];
    assign root      = r_reg[N-1][mvml_pkg::ROOT_W-1:0];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

### rtl/mvml_div_pipe.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Depends on mvml_pkg for widths and the sideband type.
`default_nettype none

module mvml_div_pipe (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          in_valid,
    input  wire logic [mvml_pkg::ROOT_W-1:0]                   divisor,
    input  wire logic [mvml_pkg::LANES-1:0][mvml_pkg::DIVD_W-1:0] dividend,
    input  wire mvml_pkg::div_side_t                           in_side,
    output logic                                               out_valid,
    output logic [mvml_pkg::LANES-1:0][mvml_pkg::Q_W-1:0]      quotient,
    output mvml_pkg::div_side_t                                out_side
);

    localparam int N  = mvml_pkg::DV_STEPS;
    localparam int L  = mvml_pkg::LANES;
    localparam int DW = mvml_pkg::DIVD_W;
    localparam int QW = mvml_pkg::Q_W;

    logic [L-1:0][DW-1:0]       rem_src [N];
    logic [L-1:0][QW-1:0]       q_src [N];
    logic [mvml_pkg::ROOT_W-1:0] m_src [N];
    logic [L-1:0][DW-1:0]       rem_next [N];
    logic [L-1:0][QW-1:0]       q_next [N];
    logic [L-1:0][DW-1:0]       rem_reg [N];
    logic [L-1:0][QW-1:0]       q_reg [N];
    logic [mvml_pkg::ROOT_W-1:0] m_reg [N];
    logic [N-1:0]               vld_reg;
    mvml_pkg::div_side_t        side_reg [N];

    // Trial-subtract the shifted divisor in every lane
    always_comb
    begin
        logic [DW:0] trial;
        rem_src[0] = dividend;
        q_src[0]   = '0;
        m_src[0]   = divisor;
        for (int s = 1; s < N; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            q_src[s]   = q_reg[s-1];
            m_src[s]   = m_reg[s-1];
        end
        for (int s = 0; s < N; s++)
        begin
            trial = (DW+1)'(m_src[s]) << (N - 1 - s);
            for (int k = 0; k < L; k++)
            begin
                if ({1'b0, rem_src[s][k]} >= trial)
                begin
                    rem_next[s][k] = rem_src[s][k] - trial[DW-1:0];
                    q_next[s][k]   = {q_src[s][k][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][k] = rem_src[s][k];
                    q_next[s][k]   = {q_src[s][k][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    // Advance data and sideband
    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int s = 0; s < N; s++)
        begin
            rem_reg[s] <= rem_next[s];
            q_reg[s]   <= q_next[s];
            m_reg[s]   <= m_src[s];
        end
        for (int s = 1; s < N; s++)
            side_reg[s] <= side_reg[s-1];
    end

    assign out_valid = vld_reg[N-1];
    assign quotient  = q_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

### rtl/mesh_vertex_morph_lerp_core.sv
// Top level of the vertex morph core: weight register, blend stages,
// renormalization. Depends on mvml_pkg, mvml_isqrt_pipe, mvml_div_pipe.
//
//  channel   ports                       transfer
//  vertex    start, busy, vin            start high while busy low
//  weight    weight_we, weight_wdata     weight_we high
//  result    done, vout                  done high for one cycle
//
// One vertex enters per cycle; busy stays low.
// The pipeline is six blend stages, the 31-step square-root
// pipeline, one divider setup stage, the 15-step divider, one output stage.
// Reset clears all valid bits and the weight register.
// The result side cannot stall, so the pipeline always advances.
`default_nettype none
`include "mesh_vertex_morph_lerp_core_defines.svh"

module mesh_vertex_morph_lerp_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire mvml_pkg::vin_t                   vin,
    input  wire logic                             weight_we,
    input  wire logic [mvml_pkg::WGT_W-1:0]       weight_wdata,
    output logic                                  done,
    output mvml_pkg::vout_t                       vout
);

    localparam int L = mvml_pkg::LANES;
    localparam logic [mvml_pkg::WGT_W-1:0] ONE_W = 17'd65536;

    logic [mvml_pkg::WGT_W-1:0] weight_reg;
    logic [mvml_pkg::WGT_W-1:0] w_clamp;
    logic                       accept;

    // stage A
    logic                       a_valid_reg;
    logic [L-1:0][15:0]         a_new_pos_reg;
    logic [L-1:0][15:0]         a_old_pos_reg;
    logic [mvml_pkg::WGT_W-1:0] a_w_reg;
    logic [mvml_pkg::WGT_W-1:0] a_nw_reg;
    logic                       a_wz_reg;
    logic signed [15:0]         a_tlat_reg [2];
    logic signed [15:0]         a_tlatc_reg [2];
    logic signed [15:0]         a_tlng_reg [2];
    logic signed [15:0]         a_tlngc_reg [2];
    logic [15:0]                code_sel [2];

    // stage B
    logic                       b_valid_reg;
    logic signed [34:0]         b_psum_reg [L];
    logic signed [31:0]         b_n_reg [2][L];
    logic [mvml_pkg::WGT_W-1:0] b_w_reg;
    logic [mvml_pkg::WGT_W-1:0] b_nw_reg;
    logic                       b_wz_reg;

    // stage C
    logic                       c_valid_reg;
    logic [L-1:0][19:0]         c_pos_reg;
    logic [L-1:0][15:0]         c_unb_reg;
    logic signed [46:0]         c_po_reg [L];
    logic signed [46:0]         c_pn_reg [L];
    logic                       c_wz_reg;

    // stage D
    logic                       d_valid_reg;
    logic [L-1:0][19:0]         d_pos_reg;
    logic [L-1:0][15:0]         d_unb_reg;
    logic signed [31:0]         d_c_reg [L];
    logic                       d_wz_reg;

    // stage E
    logic                       e_valid_reg;
    logic [L-1:0][19:0]         e_pos_reg;
    logic [L-1:0][15:0]         e_unb_reg;
    logic [60:0]                e_sq_reg [L];
    logic [L-1:0][mvml_pkg::CABS_W-1:0] e_abs_reg;
    logic [L-1:0]               e_neg_reg;
    logic                       e_wz_reg;

    // stage F
    logic                       f_valid_reg;
    logic [mvml_pkg::SQ_W-1:0]  f_sum_reg;
    mvml_pkg::sq_side_t         f_side_reg;

    // square root
    logic                       sq_valid;
    logic [mvml_pkg::ROOT_W-1:0] sq_root;
    mvml_pkg::sq_side_t         sq_side;

    // stage G
    logic                       g_valid_reg;
    logic [mvml_pkg::ROOT_W-1:0] g_m_reg;
    logic [L-1:0][mvml_pkg::DIVD_W-1:0] g_div_reg;
    mvml_pkg::div_side_t        g_side_reg;

    // divider
    logic                       dv_valid;
    logic [L-1:0][mvml_pkg::Q_W-1:0] dv_q;
    mvml_pkg::div_side_t        dv_side;
    logic                       quot_in_range;

    // output
    logic                       done_reg;
    mvml_pkg::vout_t            vout_reg;
    logic [L-1:0][15:0]         h_norm;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign w_clamp = (weight_reg > ONE_W) ? ONE_W : weight_reg;
    assign code_sel[0] = vin.new_normal_code;
    assign code_sel[1] = vin.old_normal_code;

    // Hold the blend weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= '0;
        else if (weight_we)
            weight_reg <= weight_wdata;
    end

    // Advance valid bits of the blend stages, stage G and the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= sq_valid;
            done_reg    <= dv_valid;
        end
    end

    // Stage A: capture the vertex, clamp the weight, read the sine table
    always_ff @(posedge clk)
    begin
        a_new_pos_reg <= {vin.new_pos_z, vin.new_pos_y, vin.new_pos_x};
        a_old_pos_reg <= {vin.old_pos_z, vin.old_pos_y, vin.old_pos_x};
        a_w_reg  <= w_clamp;
        a_nw_reg <= ONE_W - w_clamp;
        a_wz_reg <= (w_clamp == '0);
        for (int n = 0; n < 2; n++)
        begin
            a_tlat_reg[n]  <= mvml_pkg::SINE_LUT[code_sel[n][15:8]];
            a_tlatc_reg[n] <= mvml_pkg::SINE_LUT[code_sel[n][15:8] + 8'd64];
            a_tlng_reg[n]  <= mvml_pkg::SINE_LUT[code_sel[n][7:0]];
            a_tlngc_reg[n] <= mvml_pkg::SINE_LUT[code_sel[n][7:0] + 8'd64];
        end
    end

    // Stage B: weight the positions, decode both normals to Q28
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < L; k++)
            b_psum_reg[k] <= $signed(a_old_pos_reg[k]) * $signed({1'b0, a_w_reg})
                           + $signed(a_new_pos_reg[k]) * $signed({1'b0, a_nw_reg});
        for (int n = 0; n < 2; n++)
        begin
            b_n_reg[n][0] <= a_tlatc_reg[n] * a_tlng_reg[n];
            b_n_reg[n][1] <= a_tlat_reg[n] * a_tlng_reg[n];
            b_n_reg[n][2] <= $signed({{2{a_tlngc_reg[n][15]}}, a_tlngc_reg[n], 14'd0});
        end
        b_w_reg  <= a_w_reg;
        b_nw_reg <= a_nw_reg;
        b_wz_reg <= a_wz_reg;
    end

    // Stage C: round positions and the unblended normal, weight the normals
    always_ff @(posedge clk)
    begin
        logic signed [34:0] ps;
        logic signed [31:0] un;
        for (int k = 0; k < L; k++)
        begin
            ps = b_psum_reg[k] + 35'sd2048;
            un = b_n_reg[0][k] + 32'sd8192;
            c_pos_reg[k] <= ps[31:12];
            c_unb_reg[k] <= un[29:14];
            c_po_reg[k]  <= b_n_reg[1][k] * $signed({1'b0, b_w_reg});
            c_pn_reg[k]  <= b_n_reg[0][k] * $signed({1'b0, b_nw_reg});
        end
        c_wz_reg <= b_wz_reg;
    end

    // Stage D: sum and round the blended normal to Q30
    always_ff @(posedge clk)
    begin
        logic signed [46:0] cs;
        for (int k = 0; k < L; k++)
        begin
            cs = c_po_reg[k] + c_pn_reg[k] + 47'sd8192;
            d_c_reg[k] <= cs[45:14];
        end
        d_pos_reg <= c_pos_reg;
        d_unb_reg <= c_unb_reg;
        d_wz_reg  <= c_wz_reg;
    end

    // Stage E: square each component, split sign and magnitude
    always_ff @(posedge clk)
    begin
        logic signed [63:0] sqp;
        logic signed [31:0] ab;
        for (int k = 0; k < L; k++)
        begin
            sqp = d_c_reg[k] * d_c_reg[k];
            ab  = d_c_reg[k][31] ? -d_c_reg[k] : d_c_reg[k];
            e_sq_reg[k]  <= sqp[60:0];
            e_abs_reg[k] <= ab[mvml_pkg::CABS_W-1:0];
            e_neg_reg[k] <= d_c_reg[k][31];
        end
        e_pos_reg <= d_pos_reg;
        e_unb_reg <= d_unb_reg;
        e_wz_reg  <= d_wz_reg;
    end

    // Stage F: sum the squares
    always_ff @(posedge clk)
    begin
        f_sum_reg <= {1'b0, e_sq_reg[0]} + {1'b0, e_sq_reg[1]} + {1'b0, e_sq_reg[2]};
        f_side_reg.pos   <= e_pos_reg;
        f_side_reg.unb   <= e_unb_reg;
        f_side_reg.wz    <= e_wz_reg;
        f_side_reg.c_abs <= e_abs_reg;
        f_side_reg.c_neg <= e_neg_reg;
    end

    mvml_isqrt_pipe u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .radicand  (f_sum_reg),
        .in_side   (f_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // Stage G: form the rounded dividends for the unit scaling
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < L; k++)
            g_div_reg[k] <= {sq_side.c_abs[k], 14'd0}
                          + mvml_pkg::DIVD_W'(sq_root[mvml_pkg::ROOT_W-1:1]);
        g_m_reg <= sq_root;
        g_side_reg.pos    <= sq_side.pos;
        g_side_reg.unb    <= sq_side.unb;
        g_side_reg.wz     <= sq_side.wz;
        g_side_reg.c_neg  <= sq_side.c_neg;
        g_side_reg.m_zero <= (sq_root == '0);
    end

    mvml_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid_reg),
        .divisor   (g_m_reg),
        .dividend  (g_div_reg),
        .in_side   (g_side_reg),
        .out_valid (dv_valid),
        .quotient  (dv_q),
        .out_side  (dv_side)
    );

    // Unit scaling never exceeds one in any lane
    assign quot_in_range = (dv_q[0] <= 15'd16384) && (dv_q[1] <= 15'd16384)
                        && (dv_q[2] <= 15'd16384);

    // Apply signs, drop a zero-length normal, pick the unblended path
    always_comb
    begin
        logic [15:0] q;
        for (int k = 0; k < L; k++)
        begin
            q = dv_side.m_zero ? 16'd0 : {1'b0, dv_q[k]};
            if (dv_side.wz)
                h_norm[k] = dv_side.unb[k];
            else
                h_norm[k] = dv_side.c_neg[k] ? -q : q;
        end
    end

    // Hold the result for its one-cycle transfer
    always_ff @(posedge clk)
    begin
        vout_reg.out_pos_x  <= dv_side.pos[0];
        vout_reg.out_pos_y  <= dv_side.pos[1];
        vout_reg.out_pos_z  <= dv_side.pos[2];
        vout_reg.out_norm_x <= h_norm[0];
        vout_reg.out_norm_y <= h_norm[1];
        vout_reg.out_norm_z <= h_norm[2];
    end

    assign done = done_reg;
    assign vout = vout_reg;

    `MVML_ASSERT_RANGE(a_norm_x_range, done, vout.out_norm_x, -16'sd16384, 16'sd16384)
    `MVML_ASSERT_RANGE(a_norm_y_range, done, vout.out_norm_y, -16'sd16384, 16'sd16384)
    `MVML_ASSERT_RANGE(a_norm_z_range, done, vout.out_norm_z, -16'sd16384, 16'sd16384)
    `MVML_ASSERT_IMPL(a_zero_root, sq_valid && (sq_root == '0), sq_side.c_abs == '0)
    `MVML_ASSERT_IMPL(a_quot_bound, dv_valid && !dv_side.m_zero, quot_in_range)

endmodule

`default_nettype wire
